// ----- rtl/msg_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msg_pkg
// Shared widths, register indexes and types of the multi-stop gradient unit.
// ----------------------------------------------------------------------------
package msg_pkg;

  // Parameter defaults
  localparam int MAX_STOPS_DEF = 4;
  localparam int POS_BITS_DEF  = 12;

  // Configuration port
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int NUM_STOP_REGS  = 4;

  // Register fields
  localparam int LEN_W      = 12;
  localparam int CNT_W      = 3;
  localparam int FRAC_W     = 8;
  localparam int FRAC_SHIFT = 8;
  localparam int COLOR_W    = 24;
  localparam int CH_W       = 8;
  localparam int NUM_CH     = 3;

  // A stop pixel is (fraction * length) >> 8.
  localparam int PIX_W = FRAC_W + LEN_W - FRAC_SHIFT;

  // Mix weight divider: quotient bits resolved per pipeline stage.
  localparam int Q_W        = 8;
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = Q_W / DIV_STEPS;
  localparam int NUM_W      = PIX_W + Q_W;

  // Channel blend and divide-by-255 approximation
  localparam int              BLEND_W    = 2 * CH_W;
  localparam int              UDIV_W     = 32;
  localparam logic [BLEND_W-1:0] UDIV_MUL = 16'h8081;
  localparam int              UDIV_SHIFT = 23;
  localparam logic [CH_W-1:0] MIX_FULL   = 8'd255;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LENGTH = 3'd0,
    REG_COUNT  = 3'd1,
    REG_STOP0  = 3'd2,
    REG_STOP1  = 3'd3,
    REG_STOP2  = 3'd4,
    REG_STOP3  = 3'd5
  } cfg_reg_e;

  // Lower and upper color of the segment that an item falls in.
  typedef struct packed {
    logic [COLOR_W-1:0] c0;
    logic [COLOR_W-1:0] c1;
  } color_pair_t;

endpackage
`default_nettype wire

// ----- rtl/msg_stop_regs.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msg_stop_regs
// Configuration registers, with per-stop pixel positions and the index of the
// last stop in use kept in registers derived from them.
// ----------------------------------------------------------------------------
module msg_stop_regs #(
  parameter int MAX_STOPS = msg_pkg::MAX_STOPS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [msg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [msg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output logic [msg_pkg::PIX_W-1:0]      pix_o   [MAX_STOPS],
  output logic [msg_pkg::COLOR_W-1:0]    color_o [MAX_STOPS],
  output logic [$clog2(MAX_STOPS)-1:0]   last_o
);
  import msg_pkg::*;

  localparam int IDX_W  = $clog2(MAX_STOPS);
  localparam int PROD_W = FRAC_W + LEN_W;

  logic [LEN_W-1:0]      len_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [CFG_DATA_W-1:0] stop_val [MAX_STOPS];
  logic [IDX_W-1:0]      last_d, last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= LEN_W'(256);
      cnt_q <= CNT_W'(2);
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_LENGTH: len_q <= cfg_wdata_i[LEN_W-1:0];
        REG_COUNT:  cnt_q <= cfg_wdata_i[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar e = 0; e < MAX_STOPS; e++) begin : g_stop
    logic [PROD_W-1:0] prod;
    logic [PIX_W-1:0]  pix_q;

    if (e < NUM_STOP_REGS) begin : g_reg
      logic [CFG_DATA_W-1:0] stop_q;
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          stop_q <= '0;
        end else if (cfg_we_i && cfg_idx_i == CFG_IDX_W'(int'(REG_STOP0) + e)) begin
          stop_q <= cfg_wdata_i;
        end
      end
      assign stop_val[e] = stop_q;
    end else begin : g_none
      // Stops without a register keep their reset value.
      assign stop_val[e] = '0;
    end

    assign prod = PROD_W'(stop_val[e][CFG_DATA_W-1 -: FRAC_W]) * PROD_W'(len_q);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        pix_q <= '0;
      end else begin
        pix_q <= prod[PROD_W-1:FRAC_SHIFT];
      end
    end

    assign pix_o[e]   = pix_q;
    assign color_o[e] = stop_val[e][COLOR_W-1:0];
  end

  // A count of zero acts as one stop; a count above the limit saturates.
  always_comb begin
    if (cnt_q == '0) begin
      last_d = '0;
    end else if (int'(cnt_q) >= MAX_STOPS) begin
      last_d = IDX_W'(MAX_STOPS - 1);
    end else begin
      last_d = IDX_W'(cnt_q - CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= IDX_W'(1);
    end else begin
      last_q <= last_d;
    end
  end

  assign last_o = last_q;

endmodule
`default_nettype wire

// ----- rtl/msg_locate.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msg_locate
// Three pipeline stages: capture the position, find the segment and its
// colors, then form the offset and span handed to the mix divider.
// ----------------------------------------------------------------------------
module msg_locate #(
  parameter int MAX_STOPS = msg_pkg::MAX_STOPS_DEF,
  parameter int POS_BITS  = msg_pkg::POS_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [POS_BITS-1:0]          position_i,
  input  logic [msg_pkg::PIX_W-1:0]    pix_i   [MAX_STOPS],
  input  logic [msg_pkg::COLOR_W-1:0]  color_i [MAX_STOPS],
  input  logic [$clog2(MAX_STOPS)-1:0] last_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [msg_pkg::PIX_W-1:0]    d_o,
  output logic [msg_pkg::PIX_W-1:0]    den_o,
  output msg_pkg::color_pair_t         colors_o
);
  import msg_pkg::*;

  localparam int IDX_W = $clog2(MAX_STOPS);
  localparam int CMP_W = (POS_BITS > PIX_W) ? POS_BITS : PIX_W;

  logic en1, en2, en3;
  logic v1_q, v2_q, v3_q;

  logic [POS_BITS-1:0] pos1_q;

  logic [CMP_W-1:0] pos_ext;
  logic [IDX_W-1:0] seg;
  logic             clamp_d;
  logic [PIX_W-1:0] lo_d, hi_d;
  color_pair_t      col_d;

  logic             clamp2_q;
  logic [CMP_W-1:0] pos2_q;
  logic [PIX_W-1:0] lo2_q, hi2_q;
  color_pair_t      col2_q;

  logic [PIX_W-1:0] d_d, den_d;
  logic [PIX_W-1:0] d3_q, den3_q;
  color_pair_t      col3_q;

  assign en3        = !v3_q || out_ready_i;
  assign en2        = !v2_q || en3;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
      if (en3) v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) pos1_q <= position_i;
  end

  assign pos_ext = CMP_W'(pos1_q);

  // First inner stop at or beyond the position; the last stop otherwise.
  always_comb begin
    seg = last_i;
    for (int k = MAX_STOPS - 1; k >= 1; k--) begin
      if (k < int'(last_i) && pos_ext <= CMP_W'(pix_i[k])) begin
        seg = IDX_W'(k);
      end
    end
  end

  always_comb begin
    clamp_d = 1'b0;
    lo_d    = pix_i[seg - IDX_W'(1)];
    hi_d    = pix_i[seg];
    col_d.c0 = color_i[seg - IDX_W'(1)];
    col_d.c1 = color_i[seg];
    if (pos_ext <= CMP_W'(pix_i[0])) begin
      clamp_d  = 1'b1;
      col_d.c0 = color_i[0];
      col_d.c1 = color_i[0];
    end else if (pos_ext >= CMP_W'(pix_i[last_i])) begin
      clamp_d  = 1'b1;
      col_d.c0 = color_i[last_i];
      col_d.c1 = color_i[last_i];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) begin
      clamp2_q <= clamp_d;
      pos2_q   <= pos_ext;
      lo2_q    <= lo_d;
      hi2_q    <= hi_d;
      col2_q   <= col_d;
    end
  end

  // A clamped item gets a zero weight, which returns the lower color as is.
  // Inside a segment the position lies at or below the upper stop, so the offset
  // fits the pixel width.
  always_comb begin
    if (clamp2_q) begin
      d_d   = '0;
      den_d = PIX_W'(1);
    end else begin
      d_d   = PIX_W'(pos2_q - CMP_W'(lo2_q));
      den_d = hi2_q - lo2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en3) begin
      d3_q   <= d_d;
      den3_q <= den_d;
      col3_q <= col2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign d_o         = d3_q;
  assign den_o       = den3_q;
  assign colors_o    = col3_q;

endmodule
`default_nettype wire

// ----- rtl/msg_divider.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msg_divider
// Pipelined restoring divider for the mix weight (offset * 255) / span.
// The quotient is at most 255, so eight bits resolve it, two bits per stage.
// ----------------------------------------------------------------------------
module msg_divider (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [msg_pkg::PIX_W-1:0] d_i,
  input  logic [msg_pkg::PIX_W-1:0] den_i,
  input  msg_pkg::color_pair_t      colors_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [msg_pkg::Q_W-1:0]   mix_o,
  output msg_pkg::color_pair_t      colors_o
);
  import msg_pkg::*;

  logic [DIV_STAGES+1:0] rdy;
  logic [DIV_STAGES:0]   vld;

  logic [NUM_W-1:0] rem [DIV_STAGES];
  logic [PIX_W-1:0] den [DIV_STAGES];
  logic [Q_W-1:0]   quo [DIV_STAGES+1];
  color_pair_t      col [DIV_STAGES+1];

  logic [NUM_W-1:0] num_d;

  assign rdy[DIV_STAGES+1] = out_ready_i;
  assign in_ready_o        = rdy[0];

  for (genvar s = 0; s <= DIV_STAGES; s++) begin : g_rdy
    assign rdy[s] = !vld[s] || rdy[s+1];
  end

  // Stage zero forms the dividend as offset * 256 - offset.
  assign num_d = {d_i, Q_W'(0)} - NUM_W'(d_i);

  logic        v0_q;
  logic [NUM_W-1:0] num0_q;
  logic [PIX_W-1:0] den0_q;
  color_pair_t      col0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (rdy[0]) begin
      v0_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[0]) begin
      num0_q <= num_d;
      den0_q <= den_i;
      col0_q <= colors_i;
    end
  end

  assign vld[0] = v0_q;
  assign rem[0] = num0_q;
  assign den[0] = den0_q;
  assign quo[0] = '0;
  assign col[0] = col0_q;

  for (genvar s = 1; s <= DIV_STAGES; s++) begin : g_step
    logic [NUM_W-1:0] r;
    logic [NUM_W-1:0] sh;
    logic [Q_W-1:0]   qq;
    logic             v_q;
    logic [Q_W-1:0]   q_q;
    color_pair_t      c_q;

    // Quotient bits come most significant first and shift in from the right.
    always_comb begin
      r  = rem[s-1];
      qq = quo[s-1];
      sh = '0;
      for (int j = 0; j < DIV_STEPS; j++) begin
        sh = NUM_W'(den[s-1]) << (Q_W - 1 - ((s - 1) * DIV_STEPS + j));
        if (r >= sh) begin
          r  = r - sh;
          qq = {qq[Q_W-2:0], 1'b1};
        end else begin
          qq = {qq[Q_W-2:0], 1'b0};
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q <= 1'b0;
      end else if (rdy[s]) begin
        v_q <= vld[s-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s]) begin
        q_q <= qq;
        c_q <= col[s-1];
      end
    end

    assign vld[s] = v_q;
    assign quo[s] = q_q;
    assign col[s] = c_q;

    if (s < DIV_STAGES) begin : g_carry
      logic [NUM_W-1:0] rem_q;
      logic [PIX_W-1:0] den_q;
      always_ff @(posedge clk_i) begin
        if (rdy[s]) begin
          rem_q <= r;
          den_q <= den[s-1];
        end
      end
      assign rem[s] = rem_q;
      assign den[s] = den_q;
    end
  end

  assign out_valid_o = vld[DIV_STAGES];
  assign mix_o       = quo[DIV_STAGES];
  assign colors_o    = col[DIV_STAGES];

endmodule
`default_nettype wire

// ----- rtl/msg_blend.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// msg_blend
// Weighted blend of the two segment colors per channel, then the
// divide-by-255 approximation, with the result held in the output register.
// ----------------------------------------------------------------------------
module msg_blend (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [msg_pkg::Q_W-1:0]   mix_i,
  input  msg_pkg::color_pair_t      colors_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [msg_pkg::CH_W-1:0]  red_o,
  output logic [msg_pkg::CH_W-1:0]  green_o,
  output logic [msg_pkg::CH_W-1:0]  blue_o
);
  import msg_pkg::*;

  logic en1, en2;
  logic v1_q, v2_q;

  logic [CH_W-1:0]    imix;
  logic [BLEND_W-1:0] sum_d [NUM_CH];
  logic [BLEND_W-1:0] sum_q [NUM_CH];
  logic [UDIV_W-1:0]  prod  [NUM_CH];
  logic [COLOR_W-1:0] rgb_d, rgb_q;

  assign en2        = !v2_q || out_ready_i;
  assign en1        = !v1_q || en2;
  assign in_ready_o = en1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (en1) v1_q <= in_valid_i;
      if (en2) v2_q <= v1_q;
    end
  end

  assign imix = MIX_FULL - CH_W'(mix_i);

  // Channel 0 is red in the top byte of the color.
  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sum_d[ch] = BLEND_W'(colors_i.c1[COLOR_W-1-ch*CH_W -: CH_W]) * BLEND_W'(mix_i)
                + BLEND_W'(colors_i.c0[COLOR_W-1-ch*CH_W -: CH_W]) * BLEND_W'(imix);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en1) sum_q <= sum_d;
  end

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      prod[ch] = UDIV_W'(sum_q[ch]) * UDIV_W'(UDIV_MUL);
      rgb_d[COLOR_W-1-ch*CH_W -: CH_W] = prod[ch][UDIV_SHIFT +: CH_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en2) rgb_q <= rgb_d;
  end

  assign out_valid_o = v2_q;
  assign red_o       = rgb_q[COLOR_W-1 -: CH_W];
  assign green_o     = rgb_q[COLOR_W-1-CH_W -: CH_W];
  assign blue_o      = rgb_q[CH_W-1:0];

endmodule
`default_nettype wire

// ----- rtl/multi_stop_gradient_color_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: ten register stages, namely three locate stages, the dividend stage,
//   four divider stages (two quotient bits each), the blend stage and the
//   divide-by-255 output register.
// Throughput: one item per cycle while the output is not stalled; every stage
//   is a single registered step.
// Reset: registers take their reset values and the pipeline empties at once.
// ----------------------------------------------------------------------------
// multi_stop_gradient_color_unit
// Maps a position along a multi-stop linear gradient to an RGB888 color.
// ----------------------------------------------------------------------------
module multi_stop_gradient_color_unit #(
  parameter int MAX_STOPS = msg_pkg::MAX_STOPS_DEF,
  parameter int POS_BITS  = msg_pkg::POS_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [msg_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [msg_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [POS_BITS-1:0]            position_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [msg_pkg::CH_W-1:0]       red_o,
  output logic [msg_pkg::CH_W-1:0]       green_o,
  output logic [msg_pkg::CH_W-1:0]       blue_o
);
  import msg_pkg::*;

  localparam int IDX_W = $clog2(MAX_STOPS);

  logic [PIX_W-1:0]   pix   [MAX_STOPS];
  logic [COLOR_W-1:0] color [MAX_STOPS];
  logic [IDX_W-1:0]   last;

  logic        loc_ready;
  logic        loc_valid, div_ready;
  logic [PIX_W-1:0] loc_d, loc_den;
  color_pair_t loc_colors;

  logic        div_valid, bl_ready;
  logic [Q_W-1:0] div_mix;
  color_pair_t div_colors;

  msg_stop_regs #(
    .MAX_STOPS (MAX_STOPS)
  ) u_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .pix_o       (pix),
    .color_o     (color),
    .last_o      (last)
  );

  msg_locate #(
    .MAX_STOPS (MAX_STOPS),
    .POS_BITS  (POS_BITS)
  ) u_locate (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (loc_ready),
    .position_i  (position_i),
    .pix_i       (pix),
    .color_i     (color),
    .last_i      (last),
    .out_valid_o (loc_valid),
    .out_ready_i (div_ready),
    .d_o         (loc_d),
    .den_o       (loc_den),
    .colors_o    (loc_colors)
  );

  msg_divider u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (loc_valid),
    .in_ready_o  (div_ready),
    .d_i         (loc_d),
    .den_i       (loc_den),
    .colors_i    (loc_colors),
    .out_valid_o (div_valid),
    .out_ready_i (bl_ready),
    .mix_o       (div_mix),
    .colors_o    (div_colors)
  );

  msg_blend u_blend (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (div_valid),
    .in_ready_o  (bl_ready),
    .mix_i       (div_mix),
    .colors_i    (div_colors),
    .out_valid_o (out_valid_o),
    .out_ready_i (!out_stall_i),
    .red_o       (red_o),
    .green_o     (green_o),
    .blue_o      (blue_o)
  );

  assign in_stall_o = !loc_ready;

endmodule
`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-stop gradient color unit testbench
// Drives pixel positions through the valid/stall input channel under a series
// of gradient setups. Each accepted item is turned into its expected RGB888
// color by a local model of the stop search and blend. Every result is checked
// against the oldest expected color. Both channels idle at random.
// ----------------------------------------------------------------------------
module testbench;
  import msg_pkg::*;

  localparam int POS_W      = POS_BITS_DEF;
  localparam int NSTOPS     = MAX_STOPS_DEF;
  localparam int GAP_PCT    = 26;
  localparam int WDOG_LIMIT = 4000;

  // These indexes lie past the register list, so writes to them are dropped.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [POS_W-1:0]      position_i  = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [CH_W-1:0]       red_o;
  logic [CH_W-1:0]       green_o;
  logic [CH_W-1:0]       blue_o;

  multi_stop_gradient_color_unit uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .position_i (position_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .red_o      (red_o),
    .green_o    (green_o),
    .blue_o     (blue_o)
  );

  always #6 clk_i = ~clk_i;

  // Shadow copy of the gradient registers.
  logic [LEN_W-1:0]   len_r;
  logic [CNT_W-1:0]   count_r;
  logic [31:0]        stop_r [NSTOPS];

  logic [POS_W-1:0]   position_q [$];
  rgb_t               color_q [$];
  logic               no_gaps    = 1'b0;
  int                 mismatches = 0;
  int                 quiet_cycles = 0;

  function automatic int unsigned stop_pixel(input logic [31:0] s);
    int unsigned f;
    int unsigned l;
    f = s[31:24];
    l = len_r;
    return (f * l) >> FRAC_SHIFT;
  endfunction

  function automatic rgb_t solid(input logic [31:0] s);
    return rgb_t'(s[COLOR_W-1:0]);
  endfunction

  function automatic rgb_t gradient_color(input logic [POS_W-1:0] pos);
    int unsigned     n;
    int unsigned     i;
    int unsigned     p;
    int unsigned     lo;
    int unsigned     hi;
    int unsigned     mix;
    int unsigned     a;
    int unsigned     b;
    int unsigned     sh;
    longint unsigned acc;
    logic [31:0]     c0;
    logic [31:0]     c1;
    logic [23:0]     mixed;
    p = pos;
    n = count_r;
    if (n < 1) n = 1;
    if (n > NSTOPS) n = NSTOPS;
    lo = stop_pixel(stop_r[0]);
    if (p <= lo) return solid(stop_r[0]);
    hi = stop_pixel(stop_r[n-1]);
    if (p >= hi) return solid(stop_r[n-1]);
    i = 1;
    while (i < n - 1 && p > stop_pixel(stop_r[i])) i++;
    lo = stop_pixel(stop_r[i-1]);
    hi = stop_pixel(stop_r[i]);
    if (hi <= lo || p <= lo) return solid(stop_r[i-1]);
    mix = ((p - lo) * 255) / (hi - lo);
    if (mix > 255) mix = 255;
    c0 = stop_r[i-1];
    c1 = stop_r[i];
    for (int ch = 0; ch < NUM_CH; ch++) begin
      sh  = 16 - 8 * ch;
      a   = (c0 >> sh) & 8'hFF;
      b   = (c1 >> sh) & 8'hFF;
      acc = b * mix + a * (255 - mix);
      acc = (acc * 64'h8081) >> UDIV_SHIFT;
      mixed[sh +: 8] = acc[7:0];
    end
    return rgb_t'(mixed);
  endfunction

  // Input driver: an item stays on the port while it is stalled.
  always @(posedge clk_i) begin : drive_proc
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) color_q.push_back(gradient_color(position_i));
      if (in_valid_i && in_stall_o) begin
        // hold the stalled item
      end else if (position_q.size() != 0 &&
                   (no_gaps || $urandom_range(99) >= GAP_PCT)) begin
        in_valid_i <= 1'b1;
        position_i <= position_q.pop_front();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result monitor and output back-pressure.
  always @(posedge clk_i) begin : check_proc
    rgb_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (color_q.size() == 0) begin
        $display("%0t: result with nothing expected: red %0d green %0d blue %0d",
                 $time, red_o, green_o, blue_o);
        mismatches++;
      end else begin
        want = color_q.pop_front();
        if (red_o !== want.red) begin
          $display("%0t: red expected %0d, actual %0d", $time, want.red, red_o);
          mismatches++;
        end
        if (green_o !== want.green) begin
          $display("%0t: green expected %0d, actual %0d", $time, want.green, green_o);
          mismatches++;
        end
        if (blue_o !== want.blue) begin
          $display("%0t: blue expected %0d, actual %0d", $time, want.blue, blue_o);
          mismatches++;
        end
      end
    end
    out_stall_i <= rst_ni && !no_gaps && ($urandom_range(99) < GAP_PCT);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
        $display("FAIL multi_stop_gradient_color_unit");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    case (idx)
      REG_LENGTH: len_r   = data[LEN_W-1:0];
      REG_COUNT:  count_r = data[CNT_W-1:0];
      REG_STOP0, REG_STOP1, REG_STOP2, REG_STOP3: stop_r[idx - REG_STOP0] = data;
      default: ;
    endcase
  endtask

  // Upper bits of the length and count writes carry junk that must be ignored.
  task automatic load_gradient(input int unsigned len, input int unsigned cnt,
                               input logic [31:0] s0, input logic [31:0] s1,
                               input logic [31:0] s2, input logic [31:0] s3);
    write_reg(REG_LENGTH, ($urandom() & 32'hFFFF_F000) | len);
    write_reg(REG_COUNT, ($urandom() & 32'hFFFF_FFF8) | cnt);
    write_reg(REG_STOP0, s0);
    write_reg(REG_STOP1, s1);
    write_reg(REG_STOP2, s2);
    write_reg(REG_STOP3, s3);
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (position_q.size() != 0 || in_valid_i || color_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic random_phase(input int items);
    int unsigned fr [NSTOPS];
    logic [23:0] col [NSTOPS];
    int unsigned len;
    int unsigned cnt;
    int unsigned top;
    int unsigned tmp;
    int unsigned pick;
    int          p;
    pick = $urandom_range(9);
    case (pick)
      0:       len = 0;
      1:       len = (1 << LEN_W) - 1;
      2:       len = $urandom_range(64);
      default: len = $urandom_range((1 << LEN_W) - 1);
    endcase
    if ($urandom_range(4) == 0) cnt = $urandom_range(7);
    else cnt = $urandom_range(NSTOPS, 2);
    for (int k = 0; k < NSTOPS; k++) begin
      fr[k]  = $urandom_range(255);
      col[k] = 24'($urandom());
    end
    // Mostly sorted stops; the rest stay in random order.
    if ($urandom_range(9) < 8) begin
      for (int m = 0; m < NSTOPS - 1; m++)
        for (int k = 0; k < NSTOPS - 1 - m; k++)
          if (fr[k] > fr[k+1]) begin
            tmp = fr[k];
            fr[k] = fr[k+1];
            fr[k+1] = tmp;
          end
      if ($urandom_range(5) == 0) fr[2] = fr[1];
    end
    wait_idle();
    load_gradient(len, cnt, {fr[0][7:0], col[0]}, {fr[1][7:0], col[1]},
                  {fr[2][7:0], col[2]}, {fr[3][7:0], col[3]});
    if ($urandom_range(3) == 0) write_reg(REG_SPARE_LO, $urandom());
    if ($urandom_range(3) == 0) write_reg(REG_SPARE_HI, $urandom());
    top = 0;
    for (int k = 0; k < NSTOPS; k++) if (fr[k] > top) top = fr[k];
    top = ((top * len) >> FRAC_SHIFT) + 4;
    if (top > (1 << POS_W) - 1) top = (1 << POS_W) - 1;
    for (int j = 0; j < items; j++) begin
      pick = $urandom_range(99);
      if (pick < 12) begin
        p = $urandom_range((1 << POS_W) - 1);
      end else if (pick < 26) begin
        // Land on or right next to a stop pixel.
        p = ((fr[$urandom_range(NSTOPS - 1)] * len) >> FRAC_SHIFT) + $urandom_range(2) - 1;
        if (p < 0) p = 0;
        if (p > (1 << POS_W) - 1) p = (1 << POS_W) - 1;
      end else begin
        p = $urandom_range(top);
      end
      position_q.push_back(p[POS_W-1:0]);
    end
  endtask

  initial begin
    len_r   = 12'd256;
    count_r = 3'd2;
    for (int k = 0; k < NSTOPS; k++) stop_r[k] = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset setup: every stop is black at pixel zero.
    position_q.push_back(12'd0);
    position_q.push_back(12'd2048);
    position_q.push_back(12'hFFF);

    // Four sorted stops over 256 pixels, probed at and around each stop.
    wait_idle();
    load_gradient(256, 4, 32'h00_FF0000, 32'h40_00FF00, 32'h80_0000FF, 32'hFF_FFFFFF);
    write_reg(REG_SPARE_LO, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_HI, 32'hFFFF_FFFF);
    foreach (position_q[k]) ;
    position_q.push_back(12'd0);
    position_q.push_back(12'd1);
    position_q.push_back(12'd63);
    position_q.push_back(12'd64);
    position_q.push_back(12'd65);
    position_q.push_back(12'd127);
    position_q.push_back(12'd128);
    position_q.push_back(12'd200);
    position_q.push_back(12'd254);
    position_q.push_back(12'd255);
    position_q.push_back(12'hFFF);

    // A stop count of zero acts as a single stop.
    wait_idle();
    write_reg(REG_COUNT, 32'd0);
    position_q.push_back(12'd100);

    // A stop count above the maximum saturates.
    wait_idle();
    write_reg(REG_COUNT, 32'd7);
    position_q.push_back(12'd100);
    position_q.push_back(12'd300);

    wait_idle();
    write_reg(REG_COUNT, 32'd1);
    position_q.push_back(12'd50);

    // Zero length puts every stop at pixel zero.
    wait_idle();
    load_gradient(0, 4, 32'h00_123456, 32'h40_FFFFFF, 32'h80_000000, 32'hFF_ABCDEF);
    position_q.push_back(12'd0);
    position_q.push_back(12'd1);

    // Longest gradient with stops at the fraction extremes.
    wait_idle();
    load_gradient(4095, 4, 32'h00_000000, 32'h01_FFFFFF, 32'hFE_000000, 32'hFF_FFFFFF);
    position_q.push_back(12'd2000);
    position_q.push_back(12'd4079);
    position_q.push_back(12'd4080);
    position_q.push_back(12'hFFF);

    // Unsorted stops still run the same search.
    wait_idle();
    load_gradient(256, 4, 32'hC8_FF8000, 32'h32_00FF80, 32'h64_8000FF, 32'hFF_FFFFFF);
    position_q.push_back(12'd150);

    for (int ph = 0; ph < 17; ph++) begin
      wait_idle();
      no_gaps = (ph == 6);
      random_phase($urandom_range(140, 60));
    end

    wait_idle();
    no_gaps = 1'b0;
    repeat (24) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("PASS multi_stop_gradient_color_unit");
    end else begin
      $display("FAIL multi_stop_gradient_color_unit");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/msg_pkg.sv
rtl/msg_stop_regs.sv
rtl/msg_locate.sv
rtl/msg_divider.sv
rtl/msg_blend.sv
rtl/multi_stop_gradient_color_unit.sv
dv/testbench.sv
